@@ hw/rtl/ptpsrv_pkg.sv @@
// ----------------------------------------------------------------------------
// ptpsrv_pkg
// Shared types and constants of the peer delay and clock servo engine.
// ----------------------------------------------------------------------------
package ptpsrv_pkg;

	localparam int unsigned IN_DATA_W  = 272;
	localparam int unsigned OUT_DATA_W = 216;
	localparam int unsigned CFG_ADDR_W = 3;
	localparam int unsigned CFG_DATA_W = 20;

	localparam logic [1:0] KIND_REQ  = 2'd0;
	localparam logic [1:0] KIND_RSP  = 2'd1;
	localparam logic [1:0] KIND_SYNC = 2'd2;

	localparam logic [CFG_ADDR_W-1:0] REG_INTEGRAL_GAIN = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_PHASE_GAIN    = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_MAX_FREQ_STEP = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_FREQ_LIMIT    = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_MISSED_FACTOR = 3'd4;

	localparam logic [15:0] INTEGRAL_GAIN_RST = 16'd19661;
	localparam logic [15:0] PHASE_GAIN_RST    = 16'd32768;
	localparam logic [19:0] MAX_FREQ_STEP_RST = 20'd10000;
	localparam logic [19:0] FREQ_LIMIT_RST    = 20'd100000;
	localparam logic [7:0]  MISSED_FACTOR_RST = 8'd24;

	localparam logic [31:0] PPB_SCALE   = 32'd1000000000;
	localparam logic [40:0] IMPLIED_CAP = 41'h100_0000_0000;
	localparam logic [5:0]  DIV_STEPS   = 6'd39;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LATCH,
		OP_REQ,
		OP_RSUB,
		OP_RRT,
		OP_RUPD,
		OP_YSUM,
		OP_YDLY,
		OP_YOFF,
		OP_YMAG,
		OP_YNOM,
		OP_MLO,
		OP_MHI,
		OP_MACC,
		OP_PFIN,
		OP_ANOM,
		OP_SAT,
		OP_DIV,
		OP_CLMP,
		OP_TGT,
		OP_CMT,
		OP_LOAD
	} dp_op_t;

	typedef enum logic [1:0] {
		MS_PHASE,
		MS_NOM,
		MS_PPB,
		MS_IG
	} mul_sel_t;

	typedef struct packed {
		dp_op_t   op;
		mul_sel_t msel;
	} cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       fpath;
		logic       anom;
		logic       sat;
		logic       div_last;
		logic       out_free;
	} sts_t;

endpackage

@@ hw/rtl/ptpsrv_ctrl.sv @@
// ----------------------------------------------------------------------------
// ptpsrv_ctrl
// Sequencer: steps the datapath through request, response and sync work.
// ----------------------------------------------------------------------------
module ptpsrv_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  ptpsrv_pkg::sts_t  sts,
	output ptpsrv_pkg::cmd_t  cmd
);
	import ptpsrv_pkg::*;

	typedef enum logic [30:0] {
		ST_IDLE = 31'h0000_0001,
		ST_DISP = 31'h0000_0002,
		ST_REQ  = 31'h0000_0004,
		ST_RSUB = 31'h0000_0008,
		ST_RRT  = 31'h0000_0010,
		ST_RUPD = 31'h0000_0020,
		ST_YSUM = 31'h0000_0040,
		ST_YDLY = 31'h0000_0080,
		ST_YOFF = 31'h0000_0100,
		ST_YMAG = 31'h0000_0200,
		ST_YNOM = 31'h0000_0400,
		ST_PLO  = 31'h0000_0800,
		ST_PHI  = 31'h0000_1000,
		ST_PACC = 31'h0000_2000,
		ST_PFIN = 31'h0000_4000,
		ST_NLO  = 31'h0000_8000,
		ST_NHI  = 31'h0001_0000,
		ST_NACC = 31'h0002_0000,
		ST_ANOM = 31'h0004_0000,
		ST_FLO  = 31'h0008_0000,
		ST_FHI  = 31'h0010_0000,
		ST_FACC = 31'h0020_0000,
		ST_SAT  = 31'h0040_0000,
		ST_DIV  = 31'h0080_0000,
		ST_GLO  = 31'h0100_0000,
		ST_GHI  = 31'h0200_0000,
		ST_GACC = 31'h0400_0000,
		ST_CLMP = 31'h0800_0000,
		ST_TGT  = 31'h1000_0000,
		ST_CMT  = 31'h2000_0000,
		ST_LOAD = 31'h4000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d  = state_q;
		cmd.op   = OP_NONE;
		cmd.msel = MS_PHASE;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.op  = OP_LATCH;
					state_d = ST_DISP;
				end
			end
			ST_DISP: begin
				case (sts.kind)
					KIND_REQ:  state_d = ST_REQ;
					KIND_RSP:  state_d = ST_RSUB;
					KIND_SYNC: state_d = ST_YSUM;
					default:   state_d = ST_LOAD;
				endcase
			end
			ST_REQ: begin
				cmd.op  = OP_REQ;
				state_d = ST_LOAD;
			end
			ST_RSUB: begin
				cmd.op  = OP_RSUB;
				state_d = ST_RRT;
			end
			ST_RRT: begin
				cmd.op  = OP_RRT;
				state_d = ST_RUPD;
			end
			ST_RUPD: begin
				cmd.op  = OP_RUPD;
				state_d = ST_LOAD;
			end
			ST_YSUM: begin
				cmd.op  = OP_YSUM;
				state_d = ST_YDLY;
			end
			ST_YDLY: begin
				cmd.op  = OP_YDLY;
				state_d = ST_YOFF;
			end
			ST_YOFF: begin
				cmd.op  = OP_YOFF;
				state_d = ST_YMAG;
			end
			ST_YMAG: begin
				cmd.op  = OP_YMAG;
				state_d = ST_YNOM;
			end
			ST_YNOM: begin
				cmd.op  = OP_YNOM;
				state_d = ST_PLO;
			end
			ST_PLO: begin
				cmd.op   = OP_MLO;
				cmd.msel = MS_PHASE;
				state_d  = ST_PHI;
			end
			ST_PHI: begin
				cmd.op   = OP_MHI;
				cmd.msel = MS_PHASE;
				state_d  = ST_PACC;
			end
			ST_PACC: begin
				cmd.op   = OP_MACC;
				cmd.msel = MS_PHASE;
				state_d  = ST_PFIN;
			end
			ST_PFIN: begin
				cmd.op  = OP_PFIN;
				state_d = sts.fpath ? ST_NLO : ST_LOAD;
			end
			ST_NLO: begin
				cmd.op   = OP_MLO;
				cmd.msel = MS_NOM;
				state_d  = ST_NHI;
			end
			ST_NHI: begin
				cmd.op   = OP_MHI;
				cmd.msel = MS_NOM;
				state_d  = ST_NACC;
			end
			ST_NACC: begin
				cmd.op   = OP_MACC;
				cmd.msel = MS_NOM;
				state_d  = ST_ANOM;
			end
			ST_ANOM: begin
				cmd.op  = OP_ANOM;
				state_d = ST_FLO;
			end
			ST_FLO: begin
				if (sts.anom) begin
					state_d = ST_LOAD;
				end else begin
					cmd.op   = OP_MLO;
					cmd.msel = MS_PPB;
					state_d  = ST_FHI;
				end
			end
			ST_FHI: begin
				cmd.op   = OP_MHI;
				cmd.msel = MS_PPB;
				state_d  = ST_FACC;
			end
			ST_FACC: begin
				cmd.op   = OP_MACC;
				cmd.msel = MS_PPB;
				state_d  = ST_SAT;
			end
			ST_SAT: begin
				cmd.op  = OP_SAT;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (sts.sat) begin
					state_d = ST_GLO;
				end else begin
					cmd.op = OP_DIV;
					if (sts.div_last) begin
						state_d = ST_GLO;
					end
				end
			end
			ST_GLO: begin
				cmd.op   = OP_MLO;
				cmd.msel = MS_IG;
				state_d  = ST_GHI;
			end
			ST_GHI: begin
				cmd.op   = OP_MHI;
				cmd.msel = MS_IG;
				state_d  = ST_GACC;
			end
			ST_GACC: begin
				cmd.op   = OP_MACC;
				cmd.msel = MS_IG;
				state_d  = ST_CLMP;
			end
			ST_CLMP: begin
				cmd.op  = OP_CLMP;
				state_d = ST_TGT;
			end
			ST_TGT: begin
				cmd.op  = OP_TGT;
				state_d = ST_CMT;
			end
			ST_CMT: begin
				cmd.op  = OP_CMT;
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (sts.out_free) begin
					cmd.op  = OP_LOAD;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ hw/rtl/ptpsrv_dp.sv @@
// ----------------------------------------------------------------------------
// ptpsrv_dp
// Datapath: time arithmetic, shared multiplier, divider, servo state, output.
// ----------------------------------------------------------------------------
module ptpsrv_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  ptpsrv_pkg::cmd_t                       cmd,
	output ptpsrv_pkg::sts_t                       sts,
	input  logic [ptpsrv_pkg::IN_DATA_W-1:0]       s_tdata,
	input  logic [1:0]                             s_tuser,
	input  logic                                   cfg_we,
	input  logic [ptpsrv_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  logic [ptpsrv_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [ptpsrv_pkg::OUT_DATA_W-1:0]      m_tdata,
	output logic [1:0]                             m_tuser
);
	import ptpsrv_pkg::*;

	// configuration
	logic [15:0] ig_q;
	logic [15:0] pg_q;
	logic [19:0] mfs_q;
	logic [19:0] fl_q;
	logic [7:0]  msf_q;

	// persistent state
	logic [15:0]        pend_seq_q;
	logic [63:0]        req_time_q;
	logic [62:0]        dmin_q;
	logic               have_prev_q;
	logic [62:0]        prev_q;
	logic [62:0]        nom_q;
	logic signed [20:0] faccum_q;

	// latched item
	logic [1:0]  kind_q;
	logic [15:0] seq_q;
	logic [63:0] sa_q;
	logic [63:0] sb_q;
	logic [63:0] loc_q;
	logic [62:0] gt_q;

	// scratch
	logic [63:0]        ta_q;
	logic [63:0]        tb_q;
	logic [63:0]        off_q;
	logic               neg_q;
	logic [63:0]        mag_q;
	logic [62:0]        gap_q;
	logic               gpos_q;
	logic               anom_q;
	logic [63:0]        prod_s1;
	logic [95:0]        acc_q;
	logic               sat_q;
	logic [62:0]        rem_q;
	logic [39:0]        nlo_q;
	logic [39:0]        quo_q;
	logic [5:0]         div_cnt_q;
	logic signed [20:0] step_q;
	logic signed [20:0] target_q;
	logic [21:0]        rate_q;
	logic               rvalid_q;
	logic [63:0]        phase_q;

	// output
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic [1:0]            m_tuser_q;

	logic [63:0] mul_a;
	logic [31:0] mul_b;
	logic [31:0] mul_ah;
	logic [63:0] mul_p;
	logic [63:0] gap_w;
	logic [63:0] off_w;
	logic [63:0] pm_w;
	logic [63:0] div_r2;
	logic [63:0] div_sub;
	logic        div_ge;
	logic [40:0] implied;
	logic [40:0] smag;
	logic [19:0] cs;
	logic signed [21:0] sum_w;
	logic signed [21:0] fl_w;
	logic        is_sync;
	logic        rsp_ok;
	logic [62:0] cand;
	logic [70:0] gap16;

	always_comb begin
		case (cmd.msel)
			MS_PHASE: begin
				mul_a = mag_q;
				mul_b = {16'd0, pg_q};
			end
			MS_NOM: begin
				mul_a = {1'b0, nom_q};
				mul_b = {24'd0, msf_q};
			end
			MS_PPB: begin
				mul_a = mag_q;
				mul_b = PPB_SCALE;
			end
			MS_IG: begin
				mul_a = {23'd0, implied};
				mul_b = {16'd0, ig_q};
			end
			default: begin
				mul_a = mag_q;
				mul_b = {16'd0, pg_q};
			end
		endcase
	end

	assign mul_ah  = (cmd.op == OP_MHI) ? mul_a[63:32] : mul_a[31:0];
	assign mul_p   = 64'(mul_ah) * 64'(mul_b);
	assign gap_w   = {1'b0, gt_q} - {1'b0, prev_q};
	assign off_w   = loc_q - ta_q;
	assign pm_w    = acc_q[79:16];
	assign div_r2  = {rem_q, nlo_q[39]};
	assign div_ge  = div_r2 >= {1'b0, nom_q};
	assign div_sub = div_r2 - {1'b0, nom_q};
	assign implied = sat_q ? IMPLIED_CAP : {1'b0, quo_q};
	assign smag    = acc_q[56:16];
	assign cs      = (smag > {21'd0, mfs_q}) ? mfs_q : smag[19:0];
	assign sum_w   = {faccum_q[20], faccum_q} + {step_q[20], step_q};
	assign fl_w    = signed'({2'b00, fl_q});
	assign is_sync = (kind_q == KIND_SYNC);
	assign rsp_ok  = (seq_q == pend_seq_q) && !ta_q[63] && (ta_q[62:1] != 62'd0);
	assign cand    = ta_q[63:1];
	assign gap16   = {4'd0, gap_q, 4'd0};

	assign sts.kind     = kind_q;
	assign sts.fpath    = have_prev_q && gpos_q;
	assign sts.anom     = anom_q;
	assign sts.sat      = sat_q;
	assign sts.div_last = (div_cnt_q == 6'd0);
	assign sts.out_free = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ig_q        <= INTEGRAL_GAIN_RST;
			pg_q        <= PHASE_GAIN_RST;
			mfs_q       <= MAX_FREQ_STEP_RST;
			fl_q        <= FREQ_LIMIT_RST;
			msf_q       <= MISSED_FACTOR_RST;
			pend_seq_q  <= '0;
			req_time_q  <= '0;
			dmin_q      <= '0;
			have_prev_q <= 1'b0;
			prev_q      <= '0;
			nom_q       <= '0;
			faccum_q    <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_INTEGRAL_GAIN: ig_q  <= cfg_wdata[15:0];
					REG_PHASE_GAIN:    pg_q  <= cfg_wdata[15:0];
					REG_MAX_FREQ_STEP: mfs_q <= cfg_wdata;
					REG_FREQ_LIMIT:    fl_q  <= cfg_wdata;
					REG_MISSED_FACTOR: msf_q <= cfg_wdata[7:0];
					default: ;
				endcase
			end
			if (cmd.op == OP_LOAD) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (cmd.op)
				OP_REQ: begin
					pend_seq_q <= seq_q;
					req_time_q <= loc_q;
				end
				OP_RUPD: begin
					if (rsp_ok && ((dmin_q == 63'd0) || (cand < dmin_q))) begin
						dmin_q <= cand;
					end
				end
				OP_YNOM: begin
					if (have_prev_q && gpos_q && ((nom_q == 63'd0) || (gap_q < nom_q))) begin
						nom_q <= gap_q;
					end
				end
				OP_CMT: faccum_q <= target_q;
				OP_LOAD: begin
					if (is_sync) begin
						prev_q      <= gt_q;
						have_prev_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LATCH: begin
				kind_q   <= s_tuser;
				seq_q    <= s_tdata[15:0];
				sa_q     <= s_tdata[79:16];
				sb_q     <= s_tdata[143:80];
				loc_q    <= s_tdata[207:144];
				gt_q     <= s_tdata[270:208];
				rvalid_q <= 1'b0;
				rate_q   <= '0;
				anom_q   <= 1'b0;
			end
			OP_RSUB: begin
				ta_q <= loc_q - req_time_q;
				tb_q <= sb_q - sa_q;
			end
			OP_RRT: ta_q <= ta_q - tb_q;
			OP_YSUM: begin
				ta_q   <= sa_q + sb_q;
				gap_q  <= gap_w[62:0];
				gpos_q <= !gap_w[63] && (gap_w != 64'd0);
			end
			OP_YDLY: ta_q <= ta_q + {1'b0, dmin_q};
			OP_YOFF: off_q <= off_w;
			OP_YMAG: begin
				neg_q <= off_q[63];
				mag_q <= off_q[63] ? (64'd0 - off_q) : off_q;
			end
			OP_MLO: prod_s1 <= mul_p;
			OP_MHI: begin
				prod_s1 <= mul_p;
				acc_q   <= {32'd0, prod_s1};
			end
			OP_MACC: acc_q <= acc_q + {prod_s1, 32'd0};
			OP_PFIN: phase_q <= neg_q ? pm_w : (64'd0 - pm_w);
			OP_ANOM: anom_q <= gap16 > acc_q[70:0];
			OP_SAT: begin
				sat_q     <= {7'd0, acc_q[95:40]} >= nom_q;
				rem_q     <= {7'd0, acc_q[95:40]};
				nlo_q     <= acc_q[39:0];
				quo_q     <= '0;
				div_cnt_q <= DIV_STEPS;
			end
			OP_DIV: begin
				rem_q     <= div_ge ? div_sub[62:0] : div_r2[62:0];
				quo_q     <= {quo_q[38:0], div_ge};
				nlo_q     <= {nlo_q[38:0], 1'b0};
				div_cnt_q <= div_cnt_q - 6'd1;
			end
			OP_CLMP: step_q <= neg_q ? signed'({1'b0, cs}) : -signed'({1'b0, cs});
			OP_TGT: begin
				if (sum_w > fl_w) begin
					target_q <= fl_w[20:0];
				end else if (sum_w < -fl_w) begin
					target_q <= 21'(-fl_w);
				end else begin
					target_q <= sum_w[20:0];
				end
			end
			OP_CMT: begin
				rate_q   <= {target_q[20], target_q} - {faccum_q[20], faccum_q};
				rvalid_q <= 1'b1;
			end
			OP_LOAD: begin
				m_tdata_q[63:0]    <= is_sync ? off_q : 64'd0;
				m_tdata_q[127:64]  <= is_sync ? phase_q : 64'd0;
				m_tdata_q[149:128] <= rate_q;
				m_tdata_q[212:150] <= dmin_q;
				m_tdata_q[215:213] <= 3'd0;
				m_tuser_q          <= {rvalid_q, is_sync};
			end
			default: ;
		endcase
	end

endmodule

@@ hw/rtl/ptp_slave_delay_offset_servo_core.sv @@
// Sync work ends after the phase step without frequency path and after the
// anomaly check on a missed sync; when the implied error saturates the
// 40-step divider is skipped, otherwise it runs in full.
// Throughput: one item at a time; the next item is taken the cycle after the
// previous one has moved into the output register.
// Reset: asynchronous, clears all servo state, restores default gains.
// ----------------------------------------------------------------------------
// ptp_slave_delay_offset_servo_core
// Peer link delay measurement and PI clock servo, top level.
// ----------------------------------------------------------------------------
module ptp_slave_delay_offset_servo_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// seq_num[15:0], stamp_a[79:16], stamp_b[143:80], local_time[207:144],
	// global_time[270:208], zero pad
	input  logic [ptpsrv_pkg::IN_DATA_W-1:0]    s_tdata,
	// kind[1:0]
	input  logic [1:0]                          s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// offset[63:0], phase_step[127:64], rate_step[149:128],
	// link_delay[212:150], zero pad
	output logic [ptpsrv_pkg::OUT_DATA_W-1:0]   m_tdata,
	// sync_done[0], rate_valid[1]
	output logic [1:0]                          m_tuser,
	input  logic                                cfg_we,
	input  logic [ptpsrv_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [ptpsrv_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import ptpsrv_pkg::*;

	cmd_t cmd;
	sts_t sts;

	ptpsrv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ptpsrv_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule
